// ===== src/ffqs_pkg.sv =====
// Package: shared constants and types for the float floor quantizer.
`default_nettype none
package ffqs_pkg;
  localparam int unsigned CODE_W = 24;
  localparam logic [3:0] REG_RANGE = 4'd0;
  localparam logic [3:0] REG_PREC  = 4'd1;

  typedef struct packed {
    logic [31:0]       result_bits;
    logic [CODE_W-1:0] fixed_code;
    logic              clipped_high;
    logic              clipped_low;
    logic              is_nan;
  } ffqs_result_t;
endpackage
`default_nettype wire

// ===== src/ffqs_core.sv =====
// Combinational core: float to grid code with floor and saturation, and back to float.
`default_nettype none
module ffqs_core (
  input  wire logic [31:0]    value_bits,
  input  wire logic [3:0]     m,
  input  wire logic [3:0]     n,
  output ffqs_pkg::ffqs_result_t res
);
  import ffqs_pkg::*;

  logic        s;
  logic [7:0]  e;
  logic [22:0] f;
  logic [23:0] sig;
  logic signed [10:0] sh;
  logic [4:0]  k;
  logic [40:0] ip;
  logic        frac;
  logic [24:0] maxcode;
  logic [24:0] mincode_mag;
  logic        hi, lo;
  logic [41:0] negmag;
  logic [24:0] cmag;
  logic        cneg;
  logic [4:0]  p;
  logic [7:0]  expo;
  logic [22:0] mant;
  logic [47:0] shifted;

  always_comb begin
    s = value_bits[31];
    e = value_bits[30:23];
    f = value_bits[22:0];
    sig = (e == 8'd0) ? {1'b0, f} : {1'b1, f};
    sh = ((e == 8'd0) ? 11'sd1 : $signed({3'b000, e})) - 11'sd150 + $signed({7'd0, n});
    ip = '0;
    frac = 1'b0;
    k = 5'd0;
    if (e == 8'hFF) begin
      ip = 41'd1 << 40;
    end else if (sh >= 0) begin
      if (sh > 11'sd16) ip = (sig != 24'd0) ? (41'd1 << 40) : '0;
      else ip = {17'd0, sig} << sh[4:0];
    end else if (sh <= -11'sd32) begin
      frac = sig != 24'd0;
    end else begin
      k = 5'(-sh);
      ip = {17'd0, sig >> k};
      frac = (sig & ((24'd1 << k) - 24'd1)) != 24'd0;
    end
    maxcode = (25'd1 << (5'(m) + 5'(n) - 5'd1)) - 25'd1;
    mincode_mag = 25'd1 << (5'(m) + 5'(n) - 5'd1);
    negmag = {1'b0, ip} + {41'd0, frac};
    hi = !s && ((ip > {16'd0, maxcode}) || (ip == {16'd0, maxcode} && frac));
    lo = s && (negmag > {17'd0, mincode_mag});
    if (hi) begin
      cmag = maxcode; cneg = 1'b0;
    end else if (lo) begin
      cmag = mincode_mag; cneg = 1'b1;
    end else begin
      cmag = s ? negmag[24:0] : ip[24:0]; cneg = s;
    end
    p = 5'd0;
    for (int i = 1; i < 25; i++) if (cmag[i]) p = 5'(i);
    expo = 8'(p) + 8'd127 - 8'(n);
    shifted = {23'd0, cmag} << (5'd23 - p);
    mant = shifted[22:0];
    res.is_nan = 1'b0;
    if (e == 8'hFF && f != 23'd0) begin
      res.result_bits = value_bits | 32'h0040_0000;
      res.fixed_code = '0;
      res.clipped_high = 1'b0;
      res.clipped_low = 1'b0;
      res.is_nan = 1'b1;
    end else begin
      if (cmag == 25'd0) res.result_bits = {s, 31'd0};
      else res.result_bits = {cneg, expo, mant};
      res.fixed_code = cneg ? 24'(-cmag) : cmag[23:0];
      res.clipped_high = hi;
      res.clipped_low = lo;
    end
  end
endmodule
`default_nettype wire

// ===== src/float_floor_quantize_saturate_top.sv =====
// Top level: config registers, input register, core and result register.
// channel | ports                          | handshake
// input   | value_bits                     | start & !busy
// result  | result_bits fixed_code clipped_high clipped_low is_nan | done, one cycle
// config  | cfg_we cfg_index cfg_data       | cfg_we
// One transaction per cycle; the result passes the input register, the core and the result register.
// busy is always low; the register pipeline takes an item every cycle.
// rst clears valid flags and sets int_bits and frac_bits to 8.
`default_nettype none
module float_floor_quantize_saturate_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] value_bits,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [3:0]  cfg_data,
  output logic             done,
  output logic [31:0]      result_bits,
  output logic signed [ffqs_pkg::CODE_W-1:0] fixed_code,
  output logic             clipped_high,
  output logic             clipped_low,
  output logic             is_nan
);
  import ffqs_pkg::*;

  logic [3:0]  int_bits, frac_bits;
  logic [3:0]  m_eff, n_eff;
  logic        in_valid;
  logic [31:0] in_value;
  ffqs_result_t core_res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      int_bits <= 4'd8;
      frac_bits <= 4'd8;
    end else if (cfg_we) begin
      if (cfg_index == REG_RANGE) int_bits <= cfg_data;
      else if (cfg_index == REG_PREC) frac_bits <= cfg_data;
    end
  end

  assign m_eff = (int_bits == 4'd0) ? 4'd1 : (int_bits > 4'd12) ? 4'd12 : int_bits;
  assign n_eff = (frac_bits > 4'd12) ? 4'd12 : frac_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      in_valid <= start;
      done <= in_valid;
    end
    in_value <= value_bits;
    result_bits <= core_res.result_bits;
    fixed_code <= core_res.fixed_code;
    clipped_high <= core_res.clipped_high;
    clipped_low <= core_res.clipped_low;
    is_nan <= core_res.is_nan;
  end

  ffqs_core u_core (
    .value_bits(in_value),
    .m(m_eff),
    .n(n_eff),
    .res(core_res)
  );
endmodule
`default_nettype wire

// ===== src/ffqs_checker.sv =====
// Checker: port-level properties of the quantizer, bound to the top level.
`default_nettype none
module ffqs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [31:0] result_bits,
  input wire logic [23:0] fixed_code,
  input wire logic        clipped_high,
  input wire logic        clipped_low,
  input wire logic        is_nan
);
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 done) else $error("missing result");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2)) else $error("result without transaction");
  a_clip_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(clipped_high && clipped_low) && !(is_nan && (clipped_high || clipped_low)))
    else $error("conflicting flags");
  a_nan_code: assert property (@(posedge clk) disable iff (rst)
    done && is_nan |-> fixed_code == 24'd0) else $error("NaN code not zero");
endmodule

bind float_floor_quantize_saturate_top ffqs_checker u_ffqs_checker (.*);
`default_nettype wire
